// ----- hdl/jse_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the JSON string escaper.
package jse_pkg;

  // Upper bound on the run of output bytes that one input byte can cause
  localparam int unsigned MaxRun = 10;
  localparam int unsigned CntW   = $clog2(MaxRun + 1);
  localparam int unsigned IdxW   = $clog2(MaxRun);

  // Held UTF-8 prefix codes
  localparam logic [1:0] HeldNone = 2'd0;
  localparam logic [1:0] HeldE2   = 2'd1;
  localparam logic [1:0] HeldE280 = 2'd2;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ByteE2  = 8'hE2;
  localparam logic [7:0] Byte80  = 8'h80;
  localparam logic [7:0] ByteA8  = 8'hA8;
  localparam logic [7:0] ByteA9  = 8'hA9;
  localparam logic [7:0] CtrlMax = 8'h1F;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;    // entry 0 goes out first
    logic [CntW-1:0]        cnt;
    logic                   str_end;  // last entry is the closing quote
  } run_t;

endpackage

// ----- hdl/json_string_escaper_core.sv -----
`timescale 1ns / 1ps
// Top level of the JSON string escaper: input register, prefix state, expander, run buffer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | in_byte_i, in_first_i, in_last_i
//  out     | output    | out_valid_o / out_stall_i | out_byte_o, out_run_end_o, out_string_end_o
//
// An input byte passes through the input register and the run buffer before its
// first output byte appears. One output byte leaves per cycle while out_stall_i
// is low, and the run of one input byte is 0 to 9 bytes long.
// in_stall_o rises while the input register holds a byte and the run buffer is
// still draining the previous run. Reset clears all valid flags and the held prefix.
module json_string_escaper_core import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_first_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_run_end_o,
  output logic       out_string_end_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;
  logic [1:0] held_q;
  logic [1:0] held_d;
  logic       free;
  logic       adv;
  run_t       run;

  assign adv        = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      held_q   <= HeldNone;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= in_byte_i;
      first_q <= in_first_i;
      last_q  <= in_last_i;
    end
  end

  jse_expand u_expand (
    .byte_i  (byte_q),
    .first_i (first_q),
    .last_i  (last_q),
    .held_i  (held_q),
    .held_o  (held_d),
    .run_o   (run)
  );

  jse_drain u_drain (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (adv),
    .run_i            (run),
    .free_o           (free),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .out_run_end_o    (out_run_end_o),
    .out_string_end_o (out_string_end_o)
  );

endmodule

// ----- hdl/jse_expand.sv -----
`timescale 1ns / 1ps
// Combinational expansion of one input byte into its run of escaped output bytes.
module jse_expand import jse_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic       first_i,
  input  logic       last_i,
  input  logic [1:0] held_i,
  output logic [1:0] held_o,
  output run_t       run_o
);

  logic [1:0]      held_eff;
  logic [1:0]      held_mid;
  logic            do_plain;
  logic [1:0][7:0] rel_b;
  logic [1:0]      rel_n;
  logic [5:0][7:0] body_b;
  logic [2:0]      body_n;
  logic [1:0][7:0] tail_b;
  logic [1:0]      tail_n;
  logic [CntW-1:0] off_rel;
  logic [CntW-1:0] off_body;
  logic [CntW-1:0] off_tail;
  logic [CntW-1:0] off_quote;

  assign held_eff = first_i ? HeldNone : held_i;

  always_comb begin
    held_mid = HeldNone;
    do_plain = 1'b0;
    rel_b    = '0;
    rel_n    = '0;
    body_b   = '0;
    body_n   = '0;

    case (held_eff)
      HeldE2: begin
        if (byte_i == Byte80) begin
          held_mid = HeldE280;
        end else begin
          rel_b[0] = ByteE2;
          rel_n    = 2'd1;
          do_plain = 1'b1;
        end
      end
      HeldE280: begin
        if (byte_i == ByteA8 || byte_i == ByteA9) begin
          body_b = {(byte_i == ByteA8) ? 8'h38 : 8'h39, 8'h32, 8'h30, 8'h32, 8'h75, ChBslash};
          body_n = 3'd6;
        end else begin
          rel_b    = {Byte80, ByteE2};
          rel_n    = 2'd2;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (byte_i == ByteE2) begin
        held_mid = HeldE2;
      end else begin
        case (byte_i)
          8'h08: begin body_b[1:0] = {8'h62, ChBslash};  body_n = 3'd2; end
          8'h0C: begin body_b[1:0] = {8'h66, ChBslash};  body_n = 3'd2; end
          8'h0A: begin body_b[1:0] = {8'h6E, ChBslash};  body_n = 3'd2; end
          8'h0D: begin body_b[1:0] = {8'h72, ChBslash};  body_n = 3'd2; end
          8'h09: begin body_b[1:0] = {8'h74, ChBslash};  body_n = 3'd2; end
          ChBslash: begin body_b[1:0] = {ChBslash, ChBslash}; body_n = 3'd2; end
          ChQuote:  begin body_b[1:0] = {ChQuote, ChBslash};  body_n = 3'd2; end
          default: begin
            if (byte_i inside {[8'h00:CtrlMax]}) begin
              // \u00XY, upper-case hex
              body_b[0] = ChBslash;
              body_b[1] = 8'h75;
              body_b[2] = 8'h30;
              body_b[3] = 8'h30;
              body_b[4] = byte_i[4] ? 8'h31 : 8'h30;
              body_b[5] = (byte_i[3:0] <= 4'd9) ? (8'h30 + {4'd0, byte_i[3:0]})
                                                : (8'h37 + {4'd0, byte_i[3:0]});
              body_n = 3'd6;
            end else begin
              body_b[0] = byte_i;
              body_n    = 3'd1;
            end
          end
        endcase
      end
    end
  end

  // Release of a still-held prefix before the closing quote
  always_comb begin
    tail_b = '0;
    tail_n = '0;
    if (last_i) begin
      case (held_mid)
        HeldE2: begin
          tail_b[0] = ByteE2;
          tail_n    = 2'd1;
        end
        HeldE280: begin
          tail_b = {Byte80, ByteE2};
          tail_n = 2'd2;
        end
        default: begin
          tail_n = 2'd0;
        end
      endcase
    end
  end

  assign held_o = last_i ? HeldNone : held_mid;

  assign off_rel   = CntW'(first_i);
  assign off_body  = off_rel + CntW'(rel_n);
  assign off_tail  = off_body + CntW'(body_n);
  assign off_quote = off_tail + CntW'(tail_n);

  always_comb begin
    run_o.bytes   = '0;
    run_o.cnt     = off_quote + CntW'(last_i);
    run_o.str_end = last_i;
    if (first_i) begin
      run_o.bytes[0] = ChQuote;
    end
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < rel_n) begin
        run_o.bytes[IdxW'(off_rel + CntW'(k))] = rel_b[k];
      end
    end
    for (int k = 0; k < 6; k++) begin
      if (3'(k) < body_n) begin
        run_o.bytes[IdxW'(off_body + CntW'(k))] = body_b[k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (2'(k) < tail_n) begin
        run_o.bytes[IdxW'(off_tail + CntW'(k))] = tail_b[k];
      end
    end
    if (last_i) begin
      run_o.bytes[IdxW'(off_quote)] = ChQuote;
    end
  end

endmodule

// ----- hdl/jse_drain.sv -----
`timescale 1ns / 1ps
// Run buffer: holds one expanded run and shifts it out a byte per transaction.
module jse_drain import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  run_t       run_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_run_end_o,
  output logic       out_string_end_o
);

  logic [MaxRun-1:0][7:0] bytes_q;
  logic [CntW-1:0]        cnt_q;
  logic                   str_end_q;
  logic                   out_acc;
  logic                   last_one;

  assign out_valid_o      = (cnt_q != '0);
  assign out_acc          = out_valid_o && !out_stall_i;
  assign last_one         = (cnt_q == CntW'(1));
  assign free_o           = !out_valid_o || (out_acc && last_one);
  assign out_byte_o       = bytes_q[0];
  assign out_run_end_o    = last_one;
  assign out_string_end_o = last_one && str_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= run_i.cnt;
    end else if (out_acc) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q   <= run_i.bytes;
      str_end_q <= run_i.str_end;
    end else if (out_acc) begin
      bytes_q <= {8'h00, bytes_q[MaxRun-1:1]};
    end
  end

endmodule

// ----- hdl/jse_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the JSON string escaper, bound to the top level.
module jse_checker import jse_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       out_run_end_o,
  input logic       out_string_end_o
);

  // A stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_run_end_o) && $stable(out_string_end_o))
    else $error("output changed while stalled");

  // Raw control bytes never reach the output
  a_no_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_byte_o > CtrlMax)
    else $error("unescaped control byte on output");

  // The closing quote ends its run
  a_close_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_string_end_o |-> out_run_end_o && out_byte_o == ChQuote)
    else $error("string end not on a closing quote ending the run");

  // A run that is not finished keeps going
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_run_end_o |=> out_valid_o)
    else $error("run broken off before its last byte");

  // Input only waits behind a pending output run
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_byte_o       (out_byte_o),
  .out_run_end_o    (out_run_end_o),
  .out_string_end_o (out_string_end_o)
);

// ----- tb/json_string_escaper_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the JSON string escaper core.
module json_string_escaper_core_tb;
  import jse_pkg::*;

  localparam logic [7:0] CtrlBsp  = 8'h08;
  localparam logic [7:0] CtrlFf   = 8'h0C;
  localparam logic [7:0] CtrlLf   = 8'h0A;
  localparam logic [7:0] CtrlCr   = 8'h0D;
  localparam logic [7:0] CtrlTab  = 8'h09;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChDel    = 8'h7F;
  localparam logic [7:0] ChZero   = "0";
  localparam logic [7:0] ChUpperA = "A";
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } esc_out_t;

  // Escaped-stream predictor plus the queue of output bytes still owed by the core
  class escaped_stream_sb;
    esc_out_t    exp_q[$];
    esc_out_t    run_q[$];
    logic [1:0]  held;
    int unsigned err_cnt;

    function new();
      held    = HeldNone;
      err_cnt = 0;
    endfunction

    function void note_error(string msg);
      if (err_cnt < MaxReported) begin
        $display("[%0t] ERROR: %s", $time, msg);
      end
      err_cnt++;
    endfunction

    function void put(logic [7:0] b, logic s);
      esc_out_t e;
      e.data    = b;
      e.run_end = 1'b0;
      e.str_end = s;
      run_q.push_back(e);
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
        put(s[i], 1'b0);
      end
    endfunction

    function logic [7:0] hex_digit(logic [3:0] d);
      return (d < 4'd10) ? ChZero + {4'h0, d} : ChUpperA + {4'h0, d} - 8'd10;
    endfunction

    function void put_escaped(logic [7:0] c);
      case (c)
        CtrlBsp:  begin put(ChBslash, 1'b0); put("b", 1'b0); end
        CtrlFf:   begin put(ChBslash, 1'b0); put("f", 1'b0); end
        CtrlLf:   begin put(ChBslash, 1'b0); put("n", 1'b0); end
        CtrlCr:   begin put(ChBslash, 1'b0); put("r", 1'b0); end
        CtrlTab:  begin put(ChBslash, 1'b0); put("t", 1'b0); end
        ChBslash: begin put(ChBslash, 1'b0); put(ChBslash, 1'b0); end
        ChQuote:  begin put(ChBslash, 1'b0); put(ChQuote, 1'b0); end
        default: begin
          if (c <= CtrlMax) begin
            put_text("\\u00");
            put(hex_digit(c[7:4]), 1'b0);
            put(hex_digit(c[3:0]), 1'b0);
          end else begin
            put(c, 1'b0);
          end
        end
      endcase
    endfunction

    // A fresh E2 always starts a new held prefix
    function void put_plain(logic [7:0] c);
      if (c == ByteE2) begin
        held = HeldE2;
      end else begin
        held = HeldNone;
        put_escaped(c);
      end
    endfunction

    function void note_byte(logic [7:0] c, logic first, logic last);
      esc_out_t e;
      run_q.delete();
      if (first) begin
        held = HeldNone;
        put(ChQuote, 1'b0);
      end
      case (held)
        HeldE2: begin
          if (c == Byte80) begin
            held = HeldE280;
          end else begin
            put(ByteE2, 1'b0);
            put_plain(c);
          end
        end
        HeldE280: begin
          if (c == ByteA8) begin
            held = HeldNone;
            put_text("\\u2028");
          end else if (c == ByteA9) begin
            held = HeldNone;
            put_text("\\u2029");
          end else begin
            put(ByteE2, 1'b0);
            put(Byte80, 1'b0);
            put_plain(c);
          end
        end
        default: put_plain(c);
      endcase
      if (last) begin
        if (held == HeldE2 || held == HeldE280) put(ByteE2, 1'b0);
        if (held == HeldE280) put(Byte80, 1'b0);
        held = HeldNone;
        put(ChQuote, 1'b1);
      end
      if (run_q.size() > 0) begin
        e = run_q.pop_back();
        e.run_end = 1'b1;
        run_q.push_back(e);
      end
      foreach (run_q[i]) exp_q.push_back(run_q[i]);
    endfunction

    function void check_output(logic [7:0] b, logic re, logic se);
      esc_out_t e;
      esc_out_t got;
      got.data    = b;
      got.run_end = re;
      got.str_end = se;
      if (exp_q.size() == 0) begin
        note_error($sformatf("unexpected output byte %h run_end %b string_end %b", b, re, se));
      end else begin
        e = exp_q.pop_front();
        if (e !== got) begin
          note_error($sformatf("byte exp %h got %h, run_end exp %b got %b, string_end exp %b got %b",
                               e.data, b, e.run_end, re, e.str_end, se));
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       in_first_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       out_run_end_o;
  logic       out_string_end_o;

  escaped_stream_sb sb;
  logic [7:0]       str_q[$];
  int unsigned      snd_idle_pct;
  int unsigned      rcv_stall_pct;
  int unsigned      items_sent;

  json_string_escaper_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .in_first_i       (in_first_i),
    .in_last_i        (in_last_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .out_run_end_o    (out_run_end_o),
    .out_string_end_o (out_string_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  // Both channels: a transaction completes on a rising edge with valid high and stall low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_byte_i, in_first_i, in_last_i);
      if (out_valid_o && !out_stall_i) sb.check_output(out_byte_o, out_run_end_o, out_string_end_o);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_first_i <= f;
    in_last_i  <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_str(input logic mark_first, input logic mark_last);
    for (int i = 0; i < str_q.size(); i++) begin
      send_byte(str_q[i], mark_first && (i == 0), mark_last && (i == str_q.size() - 1));
    end
  endtask

  // Drop valid before anything that waits on rising edges
  task automatic idle_in();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_token();
    case ($urandom_range(9))
      0: begin
        str_q.push_back(ByteE2);
        str_q.push_back(Byte80);
        str_q.push_back($urandom_range(1) ? ByteA8 : ByteA9);
      end
      1: begin
        str_q.push_back(ByteE2);
        if ($urandom_range(1)) str_q.push_back(Byte80);
      end
      2, 3: str_q.push_back(8'($urandom_range(31)));
      4: begin
        case ($urandom_range(3))
          0: str_q.push_back(ChQuote);
          1: str_q.push_back(ChBslash);
          2: str_q.push_back(ChSlash);
          default: str_q.push_back(ChDel);
        endcase
      end
      default: str_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      str_q.delete();
      repeat ($urandom_range(1, 4)) add_token();
      kind = $urandom_range(99);
      if (kind < 85) begin
        send_str(1'b1, 1'b1);
      end else if (kind < 93) begin
        // continuation bytes with no opening mark
        send_str(1'b0, 1'($urandom_range(1)));
      end else begin
        // string cut off before its last mark
        send_str(1'b1, 1'b0);
      end
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_byte_i     = 8'h00;
    in_first_i    = 1'b0;
    in_last_i     = 1'b0;
    snd_idle_pct  = 20;
    rcv_stall_pct = 46;
    items_sent    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    str_q = '{8'hFF};
    send_str(1'b1, 1'b1);
    str_q = '{CtrlBsp, CtrlFf, CtrlLf, CtrlCr, CtrlTab, ChBslash, ChQuote, ChSlash};
    send_str(1'b1, 1'b1);
    // ends with a lone E2 still held
    str_q = '{8'h00, CtrlMax, 8'h1A, ByteE2};
    send_str(1'b1, 1'b1);
    // released prefixes, a new E2 after E2 80, and E2 80 held at the last byte
    str_q = '{ByteE2, Byte80, ByteA9, ByteE2, 8'h41, ByteE2, Byte80, ByteE2, Byte80};
    send_str(1'b1, 1'b1);
    // unfinished string with a held prefix, then a new string starts
    str_q = '{ByteE2, Byte80};
    send_str(1'b1, 1'b0);
    str_q = '{ByteE2, Byte80, ByteA8};
    send_str(1'b1, 1'b1);
    // bytes with no open string
    str_q = '{8'h7E, ChBslash};
    send_str(1'b0, 1'b1);

    run_random(30);
    idle_in();
    wait_drain();

    snd_idle_pct  = 46;
    rcv_stall_pct = 20;
    run_random(30);

    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    run_random(30);

    idle_in();
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (sb.exp_q.size() != 0) begin
      sb.note_error($sformatf("%0d expected output bytes never arrived", sb.exp_q.size()));
    end
    if (sb.err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/jse_pkg.sv
hdl/jse_expand.sv
hdl/jse_drain.sv
hdl/json_string_escaper_core.sv
hdl/jse_checker.sv
tb/json_string_escaper_core_tb.sv
